// ===== rtl/rotate_project_depth_test_macros.svh =====
// Assertion helpers shared by the controller and the datapath.
// Both expect signals named clk and rst in the enclosing module.
`ifndef ROTATE_PROJECT_DEPTH_TEST_MACROS_SVH
`define ROTATE_PROJECT_DEPTH_TEST_MACROS_SVH

// Same-cycle implication.
`define RPDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RPDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rpdt_pkg.sv =====
package rpdt_pkg;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_MAT, ST_VEC, ST_LIGHT, ST_SHADE,
    ST_DIV, ST_PROJ, ST_READ, ST_TEST, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SWEEP, OP_MAT, OP_VEC, OP_LIGHT, OP_SHADE,
    OP_DIV, OP_PROJ, OP_READ, OP_TEST, OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    REG_SIN_A, REG_COS_A, REG_SIN_B, REG_COS_B,
    REG_SIN_C, REG_COS_C, REG_LIGHT_VECTOR, REG_SCREEN_SHIFT
  } reg_idx_t;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // last step of each sequenced phase
  localparam step_t MAT_LAST   = 5'd13;
  localparam step_t VEC_LAST   = 5'd8;
  localparam step_t LIGHT_LAST = 5'd2;
  localparam step_t DIV_LAST   = 5'd24;
  localparam step_t PROJ_LAST  = 5'd3;

  localparam int CFG_W = 48;

  typedef struct packed {
    op_t   op;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic zd_pos;
    logic sweep_last;
    logic out_free;
  } status_t;

  // matrix-vector step -> row / column
  function automatic logic [1:0] vec_row(input step_t s);
    logic [1:0] r;
    case (s)
      5'd0, 5'd1, 5'd2: r = 2'd0;
      5'd3, 5'd4, 5'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] vec_col(input step_t s);
    logic [1:0] c;
    case (s)
      5'd0, 5'd3, 5'd6: c = 2'd0;
      5'd1, 5'd4, 5'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/rpdt_if.sv =====
interface rpdt_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [1:0]  normal_x;
  logic signed [1:0]  normal_y;
  logic signed [1:0]  normal_z;

  modport source (output valid, func, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                output ready);
endinterface

interface rpdt_out_if;
  logic        valid;
  logic        ready;
  logic        plotted;
  logic [11:0] pixel_index;
  logic [3:0]  shade_index;

  modport source (output valid, plotted, pixel_index, shade_index, input ready);
  modport sink (input valid, plotted, pixel_index, shade_index, output ready);
endinterface

// ===== rtl/rpdt_dp.sv =====
`include "rotate_project_depth_test_macros.svh"

module rpdt_dp #(
  parameter int SCREEN_WIDTH    = 128,
  parameter int SCREEN_HEIGHT   = 32,
  parameter int PROJECTION_GAIN = 40,
  parameter int VIEW_DISTANCE   = 5,
  parameter int SHADE_LEVELS    = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rpdt_pkg::cmd_t           cmd,
  output rpdt_pkg::status_t        status,
  input  logic                     cfg_we,
  input  rpdt_pkg::reg_idx_t       cfg_index,
  input  logic [rpdt_pkg::CFG_W-1:0] cfg_data,
  input  logic signed [15:0]       pos_x,
  input  logic signed [15:0]       pos_y,
  input  logic signed [15:0]       pos_z,
  input  logic signed [1:0]        normal_x,
  input  logic signed [1:0]        normal_y,
  input  logic signed [1:0]        normal_z,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     plotted,
  output logic [11:0]              pixel_index,
  output logic [3:0]               shade_index
);
  import rpdt_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int RW    = $clog2(SCREEN_HEIGHT);
  localparam int M_W   = 20;
  localparam int R_W   = 24;
  localparam int RN_W  = 22;
  localparam int L_W   = 26;
  localparam int MA_W  = 26;
  localparam int MB_W  = 22;
  localparam int P_W   = 48;
  localparam int ZD_W  = 25;
  localparam int PC_W  = 42;
  localparam int NUM_W = 56;
  localparam logic [3:0] DST_CCSB = 4'd9;
  localparam logic [3:0] DST_CS   = 4'd10;

  typedef enum logic [2:0] {MD_SET, MD_HOLD, MD_ADD, MD_SUB, MD_NEG} mode_t;

  // configuration
  logic signed [15:0] sin_a, cos_a, sin_b, cos_b, sin_c, cos_c;
  logic [47:0]        light_vector;
  logic [31:0]        screen_shift;

  // item and working registers
  logic signed [15:0]   pos_r [3];
  logic signed [1:0]    nrm_r [3];
  logic signed [M_W-1:0] m [9];
  logic signed [M_W-1:0] cc_sb, cs, tmp;
  logic signed [P_W-1:0] acc;
  logic signed [RN_W-1:0] rn_acc;
  logic signed [R_W-1:0] r [3];
  logic signed [RN_W-1:0] rn [3];
  logic signed [L_W-1:0] lum;
  logic [3:0]           shade;
  logic [ZD_W-1:0]      zd;
  logic [ZD_W:0]        rem;
  logic [ZD_W-1:0]      quo;
  logic signed [PC_W-1:0] pc, pr;
  logic signed [NUM_W-1:0] xnum, ynum;
  logic signed [31:0]   col, row;
  logic                 onscreen;
  logic [AW-1:0]        idx;
  logic [15:0]          rd_q;
  logic [AW-1:0]        sweep_cnt;
  logic                 res_plot;
  logic [11:0]          res_idx;
  logic [3:0]           res_shade;
  logic [15:0]          mem [DEPTH];

  // combinational
  logic signed [M_W-1:0]  ta, tb, qv, mval;
  logic [3:0]             tdst;
  mode_t                  tmode;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [P_W-1:0]  prod, acc_sum;
  logic [1:0]             vi, vj;
  logic signed [RN_W-1:0] rn_term, rn_sum;
  logic signed [ZD_W-1:0] zd_c;
  logic [15:0]            iz;
  logic [ZD_W:0]          dtrial;
  logic signed [33:0]     sl_prod;
  logic signed [33:0]     sl_q;
  logic [3:0]             shade_c;
  logic signed [17:0]     cx, cy;
  logic signed [NUM_W-1:0] xnum_c, ynum_c, xadj, yadj;
  logic                   onscreen_c;
  logic [AW-1:0]          idx_c;
  logic                   hit;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [15:0]            mem_wd;

  // ---------------- configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sin_a <= '0; cos_a <= 16'sd16384;
      sin_b <= '0; cos_b <= 16'sd16384;
      sin_c <= '0; cos_c <= 16'sd16384;
      light_vector <= '0;
      screen_shift <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIN_A:        sin_a <= cfg_data[15:0];
        REG_COS_A:        cos_a <= cfg_data[15:0];
        REG_SIN_B:        sin_b <= cfg_data[15:0];
        REG_COS_B:        cos_b <= cfg_data[15:0];
        REG_SIN_C:        sin_c <= cfg_data[15:0];
        REG_COS_C:        cos_c <= cfg_data[15:0];
        REG_LIGHT_VECTOR: light_vector <= cfg_data[47:0];
        REG_SCREEN_SHIFT: screen_shift <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // ---------------- rotation matrix microcode
  always_comb begin
    ta = '0; tb = '0; tdst = 4'd0; tmode = MD_HOLD;
    case (cmd.step)
      5'd0:  begin ta = M_W'(cos_c); tb = M_W'(sin_b); tdst = DST_CCSB; tmode = MD_SET; end
      5'd1:  begin ta = M_W'(sin_c); tb = M_W'(sin_b); tdst = DST_CS;   tmode = MD_SET; end
      5'd2:  begin ta = M_W'(cos_c); tb = M_W'(cos_b); tdst = 4'd0;     tmode = MD_SET; end
      5'd3:  begin ta = cc_sb;       tb = M_W'(sin_a); tmode = MD_HOLD; end
      5'd4:  begin ta = M_W'(sin_c); tb = M_W'(cos_a); tdst = 4'd1;     tmode = MD_ADD; end
      5'd5:  begin ta = M_W'(sin_c); tb = M_W'(sin_a); tmode = MD_HOLD; end
      5'd6:  begin ta = cc_sb;       tb = M_W'(cos_a); tdst = 4'd2;     tmode = MD_SUB; end
      5'd7:  begin ta = M_W'(sin_c); tb = M_W'(cos_b); tdst = 4'd3;     tmode = MD_NEG; end
      5'd8:  begin ta = M_W'(cos_c); tb = M_W'(cos_a); tmode = MD_HOLD; end
      5'd9:  begin ta = cs;          tb = M_W'(sin_a); tdst = 4'd4;     tmode = MD_SUB; end
      5'd10: begin ta = M_W'(cos_c); tb = M_W'(sin_a); tmode = MD_HOLD; end
      5'd11: begin ta = cs;          tb = M_W'(cos_a); tdst = 4'd5;     tmode = MD_ADD; end
      5'd12: begin ta = M_W'(cos_b); tb = M_W'(sin_a); tdst = 4'd7;     tmode = MD_NEG; end
      5'd13: begin ta = M_W'(cos_b); tb = M_W'(cos_a); tdst = 4'd8;     tmode = MD_SET; end
      default: ;
    endcase
  end

  // ---------------- shared multiplier
  always_comb begin
    vi = vec_row(cmd.step);
    vj = (cmd.op == OP_VEC) ? vec_col(cmd.step) : cmd.step[1:0];
    iz = (|quo[ZD_W-1:16]) ? 16'hFFFF : quo[15:0];
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MAT:   begin ma = MA_W'(ta); mb = MB_W'(tb); end
      OP_VEC:   begin ma = MA_W'(m[cmd.step[3:0]]); mb = MB_W'(pos_r[vj]); end
      OP_LIGHT: begin
        ma = MA_W'(rn[vj]);
        mb = MB_W'($signed(light_vector[16*vj +: 16]));
      end
      OP_PROJ:  begin
        ma = cmd.step[0] ? MA_W'(r[1]) : MA_W'(r[0]);
        mb = $signed({6'd0, iz});
      end
      default: ;
    endcase
    prod = ma * mb;
    qv   = M_W'(prod >>> 14);
    case (tmode)
      MD_ADD:  mval = tmp + qv;
      MD_SUB:  mval = tmp - qv;
      MD_NEG:  mval = -qv;
      default: mval = qv;
    endcase
    acc_sum = ((vj == 2'd0) ? P_W'(0) : acc) + prod;
    case (nrm_r[vj])
      2'sb01:  rn_term = RN_W'(m[cmd.step[3:0]]);
      2'sb11:  rn_term = -RN_W'(m[cmd.step[3:0]]);
      2'sb10:  rn_term = -(RN_W'(m[cmd.step[3:0]]) <<< 1);
      default: rn_term = '0;
    endcase
    rn_sum = ((vj == 2'd0) ? RN_W'(0) : rn_acc) + rn_term;
  end

  // ---------------- shade, depth, projection helpers
  always_comb begin
    sl_prod = 34'(lum) * 34'(SHADE_LEVELS);
    sl_q    = sl_prod >>> 14;
    if (lum <= 0) shade_c = 4'd0;
    else if (sl_q >= 34'(SHADE_LEVELS) && SHADE_LEVELS <= 15) shade_c = 4'(SHADE_LEVELS);
    else if (sl_q >= 34'sd15) shade_c = 4'd15;
    else shade_c = 4'(sl_q);
    zd_c   = ZD_W'(r[2]) + ZD_W'(VIEW_DISTANCE * 256);
    dtrial = {rem[ZD_W-1:0], (cmd.step == 5'd0)};
    cx     = 18'(SCREEN_WIDTH / 2) + 18'($signed(screen_shift[15:0]));
    cy     = 18'(SCREEN_HEIGHT / 2) + 18'($signed(screen_shift[31:16]));
    xnum_c = (NUM_W'(cx) <<< 24) + NUM_W'(pc) * NUM_W'(2 * PROJECTION_GAIN);
    ynum_c = (NUM_W'(cy) <<< 24) - NUM_W'(pr) * NUM_W'(PROJECTION_GAIN);
    // truncate toward zero
    xadj   = xnum + (xnum[NUM_W-1] ? NUM_W'(24'hFFFFFF) : NUM_W'(0));
    yadj   = ynum + (ynum[NUM_W-1] ? NUM_W'(24'hFFFFFF) : NUM_W'(0));
    onscreen_c = !col[31] && (col < 32'(SCREEN_WIDTH)) && !row[31] &&
                 (row < 32'(SCREEN_HEIGHT));
    idx_c  = AW'(row[RW-1:0]) * AW'(SCREEN_WIDTH) + AW'(col[CW-1:0]);
    hit    = onscreen && (rd_q < iz);
  end

  // ---------------- working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pos_r[0] <= pos_x; pos_r[1] <= pos_y; pos_r[2] <= pos_z;
        nrm_r[0] <= normal_x; nrm_r[1] <= normal_y; nrm_r[2] <= normal_z;
        res_plot <= 1'b0; res_idx <= '0; res_shade <= '0;
      end
      OP_MAT: begin
        if (cmd.step == 5'd0) m[6] <= M_W'(sin_b);
        if (tmode == MD_HOLD) tmp <= qv;
        else if (tdst == DST_CCSB) cc_sb <= mval;
        else if (tdst == DST_CS) cs <= mval;
        else m[tdst] <= mval;
      end
      OP_VEC: begin
        acc    <= acc_sum;
        rn_acc <= rn_sum;
        if (vj == 2'd2) begin
          r[vi]  <= R_W'(acc_sum >>> 14);
          rn[vi] <= rn_sum;
        end
      end
      OP_LIGHT: begin
        acc <= acc_sum;
        if (vj == 2'd2) lum <= L_W'(acc_sum >>> 14);
      end
      OP_SHADE: begin
        shade <= shade_c;
        zd    <= zd_c;
        rem   <= '0;
        quo   <= '0;
      end
      OP_DIV: begin
        if (dtrial >= {1'b0, zd}) begin
          rem <= dtrial - {1'b0, zd};
          quo <= {quo[ZD_W-2:0], 1'b1};
        end else begin
          rem <= dtrial;
          quo <= {quo[ZD_W-2:0], 1'b0};
        end
      end
      OP_PROJ: begin
        case (cmd.step)
          5'd0: pc <= PC_W'(prod);
          5'd1: pr <= PC_W'(prod);
          5'd2: begin xnum <= xnum_c; ynum <= ynum_c; end
          default: begin col <= 32'(xadj >>> 24); row <= 32'(yadj >>> 24); end
        endcase
      end
      OP_READ: begin
        onscreen <= onscreen_c;
        idx      <= idx_c;
      end
      OP_TEST: begin
        if (hit) begin
          res_plot  <= 1'b1;
          res_idx   <= 12'(idx);
          res_shade <= shade;
        end
      end
      default: ;
    endcase
  end

  // ---------------- depth store
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep_cnt;
    mem_wd = '0;
    if (cmd.op == OP_SWEEP) begin
      mem_we = 1'b1;
    end else if (cmd.op == OP_TEST && hit) begin
      mem_we = 1'b1;
      mem_wa = idx;
      mem_wd = iz;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.op == OP_READ) rd_q <= mem[idx_c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.op == OP_SWEEP) begin
      sweep_cnt <= status.sweep_last ? '0 : sweep_cnt + AW'(1);
    end
  end

  // ---------------- output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_DONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DONE) begin
      plotted     <= res_plot;
      pixel_index <= res_idx;
      shade_index <= res_shade;
    end
  end

  assign status.zd_pos     = !zd_c[ZD_W-1] && (|zd_c);
  assign status.sweep_last = (sweep_cnt == AW'(DEPTH - 1));
  assign status.out_free   = !out_valid || out_ready;

  `RPDT_ASSERT_NOW(a_shade_range, out_valid, 32'(shade_index) <= SHADE_LEVELS, "shade out of range")
  `RPDT_ASSERT_NOW(a_unplotted_zero, out_valid && !plotted, pixel_index == 12'd0 && shade_index == 4'd0, "unplotted word not zero")
  `RPDT_ASSERT_NEXT(a_sweep_wrap, cmd.op == OP_SWEEP && status.sweep_last, sweep_cnt == '0, "sweep did not wrap")

endmodule

// ===== rtl/rpdt_ctrl.sv =====
`include "rotate_project_depth_test_macros.svh"

module rpdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  input  rpdt_pkg::status_t status,
  output rpdt_pkg::cmd_t    cmd
);
  import rpdt_pkg::*;

  state_t state, state_next;
  step_t  step, step_next;
  logic   item, item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      step  <= '0;
      item  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      item  <= item_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    item_next  = item;
    cmd.op     = OP_NONE;
    cmd.step   = step;
    in_ready   = 1'b0;
    case (state)
      ST_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (status.sweep_last) state_next = item ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          item_next  = 1'b1;
          step_next  = '0;
          state_next = in_func ? ST_SWEEP : ST_MAT;
        end
      end
      ST_MAT: begin
        cmd.op = OP_MAT;
        if (step == MAT_LAST) begin
          step_next = '0; state_next = ST_VEC;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_VEC: begin
        cmd.op = OP_VEC;
        if (step == VEC_LAST) begin
          step_next = '0; state_next = ST_LIGHT;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_LIGHT: begin
        cmd.op = OP_LIGHT;
        if (step == LIGHT_LAST) begin
          step_next = '0; state_next = ST_SHADE;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_SHADE: begin
        cmd.op     = OP_SHADE;
        step_next  = '0;
        state_next = status.zd_pos ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (step == DIV_LAST) begin
          step_next = '0; state_next = ST_PROJ;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_PROJ: begin
        cmd.op = OP_PROJ;
        if (step == PROJ_LAST) begin
          step_next = '0; state_next = ST_READ;
        end else begin
          step_next = step + 5'd1;
        end
      end
      ST_READ: begin
        cmd.op     = OP_READ;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        cmd.op     = OP_TEST;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op     = OP_DONE;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `RPDT_ASSERT_NEXT(a_clear_sweeps, state == ST_IDLE && in_valid && in_func, state == ST_SWEEP, "clear word did not start sweep")
  `RPDT_ASSERT_NEXT(a_done_holds, state == ST_DONE && !status.out_free, state == ST_DONE, "result dropped while output busy")
  `RPDT_ASSERT_NEXT(a_behind_view, state == ST_SHADE && !status.zd_pos, state == ST_DONE, "point behind viewer not discarded")

endmodule

// ===== rtl/rotate_project_depth_test.sv =====
// Order: a plot word is accepted, then runs matrix build, rotate, light, shade, divide,
//   project, read, test and output; if depth <= 0 it goes from shade straight to output.
// One word at a time, through a single shared 26x22 multiplier and a one-bit-per-cycle
//   restoring divider; a new word is taken only after the last result is in the output word.
// Clear word: sweeps all SCREEN_WIDTH*SCREEN_HEIGHT entries, one per cycle.
// Reset: synchronous; runs the same sweep before ready.
module rotate_project_depth_test #(
  parameter int SCREEN_WIDTH    = 128,
  parameter int SCREEN_HEIGHT   = 32,
  parameter int PROJECTION_GAIN = 40,
  parameter int VIEW_DISTANCE   = 5,
  parameter int SHADE_LEVELS    = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  rpdt_in_if.sink                    in_ch,
  rpdt_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  rpdt_pkg::reg_idx_t         cfg_index,
  input  logic [rpdt_pkg::CFG_W-1:0] cfg_data
);
  import rpdt_pkg::*;

  // command / status between sequencer and datapath
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  // sequencer: walks matrix build, rotation, shading, divide, projection, depth test
  rpdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config registers, shared multiplier, divider, depth store, output word
  rpdt_dp #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .PROJECTION_GAIN (PROJECTION_GAIN),
    .VIEW_DISTANCE   (VIEW_DISTANCE),
    .SHADE_LEVELS    (SHADE_LEVELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pos_x       (in_ch.pos_x),
    .pos_y       (in_ch.pos_y),
    .pos_z       (in_ch.pos_z),
    .normal_x    (in_ch.normal_x),
    .normal_y    (in_ch.normal_y),
    .normal_z    (in_ch.normal_z),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .plotted     (out_ch.plotted),
    .pixel_index (out_ch.pixel_index),
    .shade_index (out_ch.shade_index)
  );

endmodule

// ===== tb/rotate_project_depth_test_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the rotate / project / depth-test block.
// A local predictor keeps its own copy of the registers and of the
// inverse-depth store, works out the result of each accepted word, and a
// checker process compares every returned word field by field, in order.
module rotate_project_depth_test_tb;
  import rpdt_pkg::*;

  localparam int SCR_W      = 128;
  localparam int SCR_H      = 32;
  localparam int GAIN       = 40;
  localparam int VIEW_DIST  = 5;
  localparam int LEVELS     = 11;
  localparam int PIXELS     = SCR_W * SCR_H;
  localparam int DRAIN_WAIT = 70;
  localparam int IDLE_LIMIT = 40000;

  logic clk;
  logic rst;
  logic cfg_we;
  reg_idx_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rpdt_in_if  in_ch ();
  rpdt_out_if out_ch ();

  rotate_project_depth_test dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    logic              func;
    logic signed [15:0] px, py, pz;
    logic signed [1:0]  nx, ny, nz;
  } point_word_t;

  typedef struct {
    logic        plotted;
    logic [11:0] pixel;
    logic [3:0]  shade;
  } pixel_word_t;

  // predictor state
  logic signed [15:0] trig [6];    // sin_a, cos_a, sin_b, cos_b, sin_c, cos_c
  logic [47:0]        light;
  logic [31:0]        shift;
  logic [15:0]        depth_store [PIXELS];

  pixel_word_t pending_pixels [$];
  int          errors;
  int          send_idle, recv_idle;
  int          hold_left;
  point_word_t last_word;

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> 14;
  endfunction

  // Computes the result of one word and updates the local depth store.
  function automatic pixel_word_t render_point(point_word_t w);
    pixel_word_t res;
    longint m [3][3];
    longint p [3], n [3], r [3], rn [3], lv [3];
    longint sa, ca, sb, cb, sc, cc, csb, ssb, lum, zd, iz, hs, vs, col, row, shd;
    int idx;
    res = '{1'b0, 12'd0, 4'd0};
    if (w.func) begin
      foreach (depth_store[k]) depth_store[k] = '0;
      return res;
    end
    sa = trig[0]; ca = trig[1]; sb = trig[2]; cb = trig[3]; sc = trig[4]; cc = trig[5];
    p[0] = w.px; p[1] = w.py; p[2] = w.pz;
    n[0] = w.nx; n[1] = w.ny; n[2] = w.nz;
    csb = mulq(cc, sb);
    ssb = mulq(sc, sb);
    m[0][0] = mulq(cc, cb);
    m[0][1] = mulq(csb, sa) + mulq(sc, ca);
    m[0][2] = mulq(sc, sa) - mulq(csb, ca);
    m[1][0] = -mulq(sc, cb);
    m[1][1] = mulq(cc, ca) - mulq(ssb, sa);
    m[1][2] = mulq(cc, sa) + mulq(ssb, ca);
    m[2][0] = sb;
    m[2][1] = -mulq(cb, sa);
    m[2][2] = mulq(cb, ca);
    for (int i = 0; i < 3; i++) begin
      r[i]  = (m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2]) >>> 14;
      rn[i] = m[i][0] * n[0] + m[i][1] * n[1] + m[i][2] * n[2];
      lv[i] = longint'($signed(light[16*i +: 16]));
    end
    lum = (lv[0] * rn[0] + lv[1] * rn[1] + lv[2] * rn[2]) >>> 14;
    shd = 0;
    if (lum > 0) begin
      shd = (LEVELS * lum) >>> 14;
      if (shd > LEVELS) shd = LEVELS;
      if (shd > 15) shd = 15;
    end
    zd = r[2] + VIEW_DIST * 256;
    if (zd <= 0) return res;            // behind the viewer
    iz = (longint'(1) << 24) / zd;
    if (iz > 65535) iz = 65535;
    hs = longint'($signed(shift[15:0]));
    vs = longint'($signed(shift[31:16]));
    // signed longint division truncates toward zero, as the projection needs
    col = ((SCR_W / 2 + hs) * (longint'(1) << 24) + r[0] * GAIN * 2 * iz)
          / (longint'(1) << 24);
    row = ((SCR_H / 2 + vs) * (longint'(1) << 24) - r[1] * GAIN * iz)
          / (longint'(1) << 24);
    if (col < 0 || col >= SCR_W || row < 0 || row >= SCR_H) return res;
    idx = int'(row * SCR_W + col);
    if (longint'(depth_store[idx]) >= iz) return res;   // nearer point kept
    depth_store[idx] = iz[15:0];
    res.plotted = 1'b1;
    res.pixel   = idx[11:0];
    res.shade   = shd[3:0];
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: ready pattern plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // checker and watchdog
  int quiet_cycles;
  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.plotted !== want.plotted) begin
          $error("plotted: expected %0d got %0d", want.plotted, out_ch.plotted);
          errors++;
        end
        if (out_ch.pixel_index !== want.pixel) begin
          $error("pixel_index: expected %0d got %0d", want.pixel, out_ch.pixel_index);
          errors++;
        end
        if (out_ch.shade_index !== want.shade) begin
          $error("shade_index: expected %0d got %0d", want.shade, out_ch.shade_index);
          errors++;
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one word, holds it until accepted, then predicts its result.
  // valid stays high into the next word unless a gap is drawn.
  task automatic send_word(point_word_t w);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= w.func;
    in_ch.pos_x    <= w.px;
    in_ch.pos_y    <= w.py;
    in_ch.pos_z    <= w.pz;
    in_ch.normal_x <= w.nx;
    in_ch.normal_y <= w.ny;
    in_ch.normal_z <= w.nz;
    do @(posedge clk); while (!in_ch.ready);
    pending_pixels.push_back(render_point(w));
    last_word = w;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Writes all eight registers back to back; call only when idle.
  task automatic load_regs(logic signed [15:0] t [6], logic [47:0] lt, logic [31:0] sh);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= (i < 6) ? CFG_W'($unsigned(t[i])) : (i == 6) ? CFG_W'(lt) : CFG_W'(sh);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    trig  = t;
    light = lt;
    shift = sh;
  endtask

  function automatic point_word_t plot_word(int x, int y, int z, int nx, int ny, int nz);
    point_word_t w;
    w.func = 1'b0;
    w.px = x[15:0]; w.py = y[15:0]; w.pz = z[15:0];
    w.nx = nx[1:0]; w.ny = ny[1:0]; w.nz = nz[1:0];
    return w;
  endfunction

  function automatic point_word_t clear_word();
    point_word_t w;
    w = plot_word(0, 0, 0, 0, 0, 0);
    w.func = 1'b1;
    return w;
  endfunction

  // Mostly on-screen points, some full range, some repeats to hit the depth test.
  function automatic point_word_t random_word();
    point_word_t w;
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return clear_word();
    w = plot_word($urandom_range(2047) - 1024, $urandom_range(1023) - 512,
                  $urandom_range(2047) - 1024, $urandom_range(3), $urandom_range(3),
                  $urandom_range(3));
    if (sel < 16) begin
      w.px = $urandom; w.py = $urandom; w.pz = $urandom;
    end else if (sel < 36 && !last_word.func) begin
      w.px = last_word.px; w.py = last_word.py;
      w.pz = last_word.pz + $signed(8'($urandom_range(64) - 32));
    end
    return w;
  endfunction

  // angle table: sin, cos pairs in Q1.14
  function automatic void pick_angles(output logic signed [15:0] t [6]);
    logic signed [15:0] sn [8] = '{0, 16384, 11585, -8192, 14189, -16384, 6270, 0};
    logic signed [15:0] cs [8] = '{16384, 0, 11585, 14189, -8192, 0, 15137, -16384};
    int k;
    for (int i = 0; i < 3; i++) begin
      k = $urandom_range(7);
      t[2*i]   = sn[k];
      t[2*i+1] = cs[k];
    end
  endfunction

  function automatic logic [47:0] random_light();
    logic [47:0] lt;
    for (int i = 0; i < 3; i++) lt[16*i +: 16] = 16'($urandom_range(32768) - 16384);
    return lt;
  endfunction

  // --- tests ---------------------------------------------------------------

  // Field extremes, every normal value, discard cases, clear, depth order.
  task automatic test_directed();
    logic signed [15:0] t [6] = '{0, 16384, 0, 16384, 0, 16384};
    load_regs(t, {16'd16384, 16'd0, 16'd0}, 32'd0);   // light along +z
    send_word(plot_word(0, 0, 0, 0, 0, 1));            // center, brightest
    send_word(plot_word(0, 0, 0, 0, 0, 1));            // equal depth, kept
    send_word(plot_word(0, 0, -256, 1, -1, -2));       // nearer, same pixel
    send_word(plot_word(0, 0, 256, 0, 0, 1));          // farther, kept
    send_word(plot_word(256, -256, 0, -2, -2, -2));
    send_word(plot_word(32767, 32767, 32767, 1, 1, 1));
    send_word(plot_word(-32768, -32768, -32768, -1, -1, -1));  // behind viewer
    send_word(plot_word(0, 0, -1280, 0, 0, 1));        // depth exactly zero
    send_word(plot_word(0, 0, -1279, 0, 0, 1));        // nearest, saturates
    send_word(plot_word(4000, 0, 0, 0, 0, 0));         // off screen right
    send_word(plot_word(0, -4000, 0, 0, 0, 0));        // off screen below
    send_word(plot_word(-203, 100, 0, 0, 1, 0));
    send_word(clear_word());
    send_word(plot_word(0, 0, 0, 0, 0, 1));            // center writes again
    send_word(plot_word(-32768, 32767, 0, 0, 0, -1));
    settle();
  endtask

  // Extreme registers: trig at full scale with the screen pushed to each edge, then identity angles with a small shift.
  task automatic test_extreme_regs();
    logic signed [15:0] t [6] = '{16384, -16384, -16384, 16384, 16384, -16384};
    load_regs(t, {16'hC000, 16'h4000, 16'hC000}, {16'h8000, 16'h7FFF});
    repeat (6) send_word(random_word());
    settle();
    t = '{-16384, 16384, 16384, -16384, -16384, 16384};
    load_regs(t, {16'h4000, 16'hC000, 16'h4000}, {16'h7FFF, 16'h8000});
    repeat (6) send_word(random_word());
    settle();
    t = '{0, 16384, 0, 16384, 0, 16384};
    load_regs(t, {16'hFFFF, 16'hFFFF, 16'hFFFF}, {16'hFFF0, 16'h0010});
    repeat (6) send_word(random_word());
    settle();
  endtask

  // Random words under fresh random angles, light and small screen offsets.
  task automatic test_random(int count);
    logic signed [15:0] t [6];
    int sets;
    sets = 3;
    for (int s = 0; s < sets; s++) begin
      pick_angles(t);
      load_regs(t, random_light(), {16'($urandom_range(16) - 8), 16'($urandom_range(40) - 20)});
      for (int i = 0; i < count / sets; i++) send_word(random_word());
      settle();
    end
  endtask

  // Result side held off for a long stretch while words keep coming,
  // then the sender waits until every result is back.
  task automatic test_backpressure();
    hold_left = 400;
    repeat (10) send_word(random_word());
    in_ch.valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    @(posedge clk);
    repeat (10) send_word(random_word());
    settle();
  endtask

  initial begin
    errors       = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    send_idle    = 0;
    recv_idle    = 0;
    last_word    = clear_word();
    trig         = '{0, 16384, 0, 16384, 0, 16384};
    light        = '0;
    shift        = '0;
    foreach (depth_store[k]) depth_store[k] = '0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_SIN_A;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.func     = 1'b0;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    in_ch.pos_z    = '0;
    in_ch.normal_x = '0;
    in_ch.normal_y = '0;
    in_ch.normal_z = '0;
    out_ch.ready   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender lightly idle, receiver mostly stalled
    send_idle = 24; recv_idle = 69;
    test_directed();
    test_random(140);
    // roles swapped
    send_idle = 69; recv_idle = 24;
    test_extreme_regs();
    test_random(140);
    test_backpressure();
    // full rate both sides
    send_idle = 0; recv_idle = 0;
    test_random(140);

    settle();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rpdt_pkg.sv
rtl/rpdt_if.sv
rtl/rpdt_dp.sv
rtl/rpdt_ctrl.sv
rtl/rotate_project_depth_test.sv
tb/rotate_project_depth_test_tb.sv
